>>> rtl/core/btff_pkg.sv
// Shared constants and command/status types for the boundary-tag allocator.
package btff_pkg;
  localparam int HeapGranules = 4096;
  localparam int GranuleBytes = 16;
  localparam int GW = $clog2(HeapGranules);   // granule index width
  localparam int SW = GW + 1;                 // size width (holds HeapGranules)
  localparam int TW = SW + 1;                 // tag width
  localparam int ShB = $clog2(GranuleBytes);

  typedef enum logic [3:0] {
    OP_NONE, OP_RD_P, OP_ALLOC_STEP, OP_RD_FREE, OP_RD_L, OP_LSTEP,
    OP_RD_R, OP_RSTEP, OP_WR_A, OP_WR_B, OP_INIT_ALLOC, OP_INIT_FREE, OP_RESULT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic walk_done;    // alloc walk stopped (found or end)
    logic fail;         // alloc cannot fit
    logic free_bad;     // free address ignored
    logic l_done;       // left merge finished
    logic r_done;       // right merge finished
    logic need_split;   // second tag pair write needed
  } sts_t;
endpackage

>>> rtl/core/btff_ctrl.sv
// Sequencer for the allocator: steps the datapath through walks and tag writes.
module btff_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           func_i,
  input  btff_pkg::sts_t sts_i,
  input  logic           out_free_i,
  output btff_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  import btff_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_AEV, S_FRD, S_LRD, S_LEV, S_RRD, S_REV, S_WA, S_WB, S_WA2, S_WB2,
    S_DONE
  } state_e;

  state_e state_q;
  logic   split_q;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: if (start_i) cmd_o.op = func_i ? OP_INIT_FREE : OP_INIT_ALLOC;
      S_ARD:  cmd_o.op = OP_RD_P;
      S_AEV:  cmd_o.op = OP_ALLOC_STEP;
      S_FRD:  cmd_o.op = OP_RD_FREE;
      S_LRD:  cmd_o.op = OP_RD_L;
      S_LEV:  cmd_o.op = OP_LSTEP;
      S_RRD:  cmd_o.op = OP_RD_R;
      S_REV:  cmd_o.op = OP_RSTEP;
      S_WA, S_WA2: cmd_o.op = OP_WR_A;
      S_WB, S_WB2: cmd_o.op = OP_WR_B;
      S_DONE: if (out_free_i) cmd_o.op = OP_RESULT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      split_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= func_i ? S_FRD : S_ARD;
        S_ARD:  state_q <= S_AEV;
        S_AEV: begin
          if (sts_i.fail) state_q <= S_DONE;
          else if (sts_i.walk_done) begin
            split_q <= sts_i.need_split;
            state_q <= S_WA;
          end else state_q <= S_ARD;
        end
        S_FRD:  state_q <= sts_i.free_bad ? S_DONE : S_LRD;
        S_LRD:  state_q <= sts_i.l_done ? S_RRD : S_LEV;
        S_LEV:  state_q <= sts_i.l_done ? S_RRD : S_LRD;
        S_RRD:  state_q <= sts_i.r_done ? S_WA : S_REV;
        S_REV:  state_q <= S_RRD;
        S_WA:   state_q <= S_WB;
        S_WB:   state_q <= split_q ? S_WA2 : S_DONE;
        S_WA2:  state_q <= S_WB2;
        S_WB2:  begin state_q <= S_DONE; split_q <= 1'b0; end
        S_DONE: if (out_free_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/btff_dp.sv
// Datapath: tag memory, walk pointers, heap top and result register.
module btff_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  btff_pkg::cmd_t cmd_i,
  input  logic [15:0]    request_bytes_i,
  input  logic [15:0]    payload_address_i,
  output btff_pkg::sts_t sts_o,
  output logic [15:0]    res_addr_o,
  output logic           res_failed_o
);
  import btff_pkg::*;

  logic [TW-1:0] mem [HeapGranules];
  logic [TW-1:0] rd_q;
  logic          rd_oob_q;
  logic [GW:0]   rd_addr;
  logic          rd_en;
  logic          we;
  logic [GW:0]   wa;
  logic [TW-1:0] wd;

  logic [SW:0]   top_q, top_d;
  logic [SW:0]   p_q, p_d, need_q, need_d, sz_q, sz_d;
  logic [SW:0]   l_q, l_d, r_q, r_d, tot_q, tot_d;
  logic [SW:0]   ws_q, ws_d, wl_q, wl_d, w2s_q, w2s_d, w2l_q, w2l_d;
  logic          wu_q, wu_d;
  logic          first_q, first_d;
  logic [15:0]   addr_q, addr_d;
  logic          fail_q, fail_d;
  logic          second_q, second_d;

  logic [SW:0] rsz;
  logic        rused;
  assign rsz   = rd_oob_q ? (SW+1)'(1) :
                 ((rd_q[TW-1:1] == '0) ? (SW+1)'(1) : {1'b0, rd_q[TW-1:1]});
  assign rused = rd_oob_q | rd_q[0];

  always_comb begin
    rd_en = 1'b0; rd_addr = '0;
    unique case (cmd_i.op)
      OP_RD_P:  begin rd_en = 1'b1; rd_addr = p_q[GW:0]; end
      OP_RD_FREE: begin rd_en = 1'b1; rd_addr = l_q[GW:0]; end
      OP_RD_L:  begin rd_en = 1'b1; rd_addr = l_q[GW:0] - 1'b1; end
      OP_RD_R:  begin rd_en = 1'b1; rd_addr = r_q[GW:0] + sz_q[GW:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr[GW-1:0]];
      rd_oob_q <= rd_addr[GW];
    end
    if (we) mem[wa[GW-1:0]] <= wd;
  end

  always_comb begin
    top_d = top_q; p_d = p_q; need_d = need_q; sz_d = sz_q;
    l_d = l_q; r_d = r_q; tot_d = tot_q; wu_d = wu_q;
    ws_d = ws_q; wl_d = wl_q; w2s_d = w2s_q; w2l_d = w2l_q;
    addr_d = addr_q; fail_d = fail_q; first_d = first_q; second_d = second_q;
    we = 1'b0; wa = '0; wd = '0;
    sts_o = '0;
    unique case (cmd_i.op)
      OP_INIT_ALLOC: begin
        p_d = '0;
        need_d = (SW+1)'(2) + (SW+1)'(({1'b0, request_bytes_i} + 17'(GranuleBytes - 1)) >> ShB);
        fail_d = 1'b0; second_d = 1'b0;
      end
      OP_ALLOC_STEP: begin
        if (p_q >= top_q) begin
          sts_o.walk_done = 1'b1;
          if (top_q + need_q > (SW+1)'(HeapGranules)) begin
            sts_o.fail = 1'b1; fail_d = 1'b1; addr_d = '0;
          end else begin
            ws_d = top_q; wl_d = need_q; wu_d = 1'b1;
            top_d = top_q + need_q;
            addr_d = 16'(top_q + 1'b1) << ShB;
          end
        end else if (!rused && (rsz >= need_q || p_q + rsz >= top_q)) begin
          sts_o.walk_done = 1'b1;
          if (rsz < need_q) begin
            if (p_q + need_q > (SW+1)'(HeapGranules)) begin
              sts_o.fail = 1'b1; fail_d = 1'b1; addr_d = '0;
            end else begin
              top_d = p_q + need_q;
              ws_d = p_q; wl_d = need_q; wu_d = 1'b1;
              addr_d = 16'(p_q + 1'b1) << ShB;
            end
          end else begin
            ws_d = p_q; wu_d = 1'b1; addr_d = 16'(p_q + 1'b1) << ShB;
            if (rsz <= need_q + 2'd2) wl_d = rsz;
            else begin
              wl_d = need_q; sts_o.need_split = 1'b1;
              w2s_d = p_q + need_q; w2l_d = rsz - need_q;
            end
          end
        end else p_d = p_q + rsz;
      end
      OP_INIT_FREE: begin
        fail_d = 1'b0; addr_d = '0; second_d = 1'b0;
        if (payload_address_i[15:ShB] == '0 ||
            (SW+1)'(payload_address_i[15:ShB]) - 1'b1 >= top_q) begin
          sts_o.free_bad = 1'b1; first_d = 1'b0;
        end else first_d = 1'b1;
        l_d = (SW+1)'(payload_address_i[15:ShB]) - 1'b1;
        r_d = (SW+1)'(payload_address_i[15:ShB]) - 1'b1;
      end
      OP_RD_FREE: sts_o.free_bad = !first_q;
      OP_RD_L: begin
        // First cycle: rd_q is tag at l (block size).
        if (first_q) begin tot_d = rsz; sz_d = rsz; first_d = 1'b0; end
        sts_o.l_done = (l_q == '0);
      end
      OP_LSTEP: begin
        if (rused || rsz > l_q) sts_o.l_done = 1'b1;
        else begin
          l_d = l_q - rsz; tot_d = tot_q + rsz;
          sts_o.l_done = (l_q == rsz);
        end
        // Restore size of r block for the right walk read address.
        sz_d = sz_q;
      end
      OP_RD_R: begin
        // rd_q holds the tag at r (its size) only when entering; use sz_q.
        sts_o.r_done = (r_q + sz_q >= top_q);
        if (sts_o.r_done) begin ws_d = l_q; wl_d = tot_q; wu_d = 1'b0; end
      end
      OP_RSTEP: begin
        if (rused) begin
          ws_d = l_q; wl_d = tot_q; wu_d = 1'b0;
          r_d = top_q; sz_d = '0;
        end else begin
          r_d = r_q + sz_q; sz_d = rsz; tot_d = tot_q + rsz;
        end
      end
      OP_WR_A: begin
        if (!fail_q && ws_q < (SW+1)'(HeapGranules)) begin
          we = 1'b1; wa = ws_q[GW:0]; wd = {wl_q[SW-1:0], wu_q};
        end
      end
      OP_WR_B: begin
        if (!fail_q && wl_q != '0 && ws_q + wl_q - 1'b1 < (SW+1)'(HeapGranules)) begin
          we = 1'b1; wa = (GW+1)'(ws_q + wl_q - 1'b1); wd = {wl_q[SW-1:0], wu_q};
        end
        if (!second_q) begin
          ws_d = w2s_q; wl_d = w2l_q; wu_d = 1'b0; second_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_q <= '0;
    else top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; need_q <= need_d; sz_q <= sz_d; l_q <= l_d; r_q <= r_d;
    tot_q <= tot_d; wu_q <= wu_d; ws_q <= ws_d; wl_q <= wl_d;
    w2s_q <= w2s_d; w2l_q <= w2l_d; addr_q <= addr_d; fail_q <= fail_d;
    first_q <= first_d; second_q <= second_d;
  end

  assign res_addr_o   = addr_q;
  assign res_failed_o = fail_q;
endmodule

>>> rtl/core/boundary_tag_first_fit_allocator.sv
// Top level: boundary-tag first-fit heap allocator with stream request/result ports.
// Allocate: each walk step reads, then evaluates a tag (each block visited, or the step
// at the heap top); then one tag pair is written, two on a split, none on a failure.
// Free: merges on both sides, then writes one tag pair; an ignored free writes none.
// One request at a time; the next is taken the cycle after the result register loads.
// Reset clears heap_top and control state; the tag memory is not cleared.
module boundary_tag_first_fit_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] request_bytes, [31:16] payload_address
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] result_address
  output logic        m_axis_tuser    // [0] failed
);
  import btff_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, start, ovalid_q, out_free;
  logic [15:0] rbytes_q, raddr_q, res_addr;
  logic res_failed;

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (start) begin
      rbytes_q <= s_axis_tdata[15:0];
      raddr_q  <= s_axis_tdata[31:16];
    end
  end

  btff_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i(s_axis_tuser), .sts_i(sts),
    .out_free_i(out_free), .cmd_o(cmd), .busy_o(busy)
  );

  btff_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .request_bytes_i(start ? s_axis_tdata[15:0] : rbytes_q),
    .payload_address_i(start ? s_axis_tdata[31:16] : raddr_q),
    .sts_o(sts), .res_addr_o(res_addr), .res_failed_o(res_failed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.op == OP_RESULT) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == OP_RESULT) begin
      m_axis_tdata <= res_addr;
      m_axis_tuser <= res_failed;
    end
  end

  assign m_axis_tvalid = ovalid_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("fail with address");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("engine idle after request");
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(busy)) else $error("result without work");
endmodule

>>> tb/sv/tb_boundary_tag_first_fit_allocator.sv
// Testbench for the boundary-tag first-fit allocator: random requests, own heap predictor.
module tb_boundary_tag_first_fit_allocator;
  import btff_pkg::HeapGranules;
  import btff_pkg::GranuleBytes;

  localparam logic FnAlloc = 1'b0;
  localparam logic FnFree  = 1'b1;

  typedef struct {
    logic [15:0] address;
    logic        failed;
  } alloc_result_t;

  class heap_scoreboard;
    int unsigned tags[HeapGranules];
    int unsigned top;
    alloc_result_t pending[$];
    int errors;

    function new();
      top = 0;
      errors = 0;
      foreach (tags[i]) tags[i] = 0;
    endfunction

    function int unsigned blk_size(int unsigned g);
      int unsigned s;
      s = (g < HeapGranules) ? (tags[g] >> 1) : 1;
      return (s == 0) ? 1 : s;
    endfunction

    function bit blk_used(int unsigned g);
      return (g < HeapGranules) ? tags[g][0] : 1'b1;
    endfunction

    function void write_tags(int unsigned start, int unsigned size, bit used);
      int unsigned t;
      t = (size << 1) | used;
      if (start < HeapGranules) tags[start] = t;
      if (size >= 1 && start + size - 1 < HeapGranules) tags[start + size - 1] = t;
    endfunction

    function alloc_result_t do_alloc(int unsigned bytes);
      alloc_result_t r;
      int unsigned need, p, sz;
      need = 2 + (bytes + GranuleBytes - 1) / GranuleBytes;
      p = 0;
      sz = 0;
      r.address = '0;
      r.failed = 1'b1;
      while (p < top) begin
        sz = blk_size(p);
        if (!blk_used(p) && (sz >= need || p + sz >= top)) break;
        p += sz;
      end
      if (p < top) begin
        if (sz < need) begin
          if (p + need > HeapGranules) return r;
          top = p + need;
          sz = need;
        end
        // A remainder of two granules or less stays inside the handed-out block.
        if (sz <= need + 2) need = sz;
        else write_tags(p + need, sz - need, 1'b0);
      end else begin
        if (top + need > HeapGranules) return r;
        p = top;
        top += need;
      end
      write_tags(p, need, 1'b1);
      r.address = 16'((p + 1) * GranuleBytes);
      r.failed = 1'b0;
      return r;
    endfunction

    function void do_free(int unsigned addr);
      int unsigned b, l, r, total, s;
      b = addr / GranuleBytes;
      if (b == 0) return;
      l = b - 1;
      if (l >= top) return;
      r = l;
      total = blk_size(l);
      while (l > 0 && !blk_used(l - 1)) begin
        s = blk_size(l - 1);
        if (s > l) break;
        l -= s;
        total += s;
      end
      while (r + blk_size(r) < top && !blk_used(r + blk_size(r))) begin
        r += blk_size(r);
        total += blk_size(r);
      end
      write_tags(l, total, 1'b0);
    endfunction

    // Called for every accepted request; returns the result the block should give.
    function alloc_result_t note_request(logic func, logic [15:0] bytes, logic [15:0] addr);
      alloc_result_t r;
      if (func == FnAlloc) begin
        r = do_alloc(bytes);
      end else begin
        do_free(addr);
        r.address = '0;
        r.failed = 1'b0;
      end
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(logic [15:0] address, logic failed);
      alloc_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: address=%0d failed=%0b", address, failed);
        return;
      end
      e = pending.pop_front();
      if (address !== e.address || failed !== e.failed) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected address=%0d failed=%0b, got address=%0d failed=%0b",
                   e.address, e.failed, address, failed);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  heap_scoreboard sb = new();
  int unsigned live_blocks[$];
  int snd_idle_pct = 24;
  int rcv_idle_pct = 57;
  bit hold_req = 1'b0;

  boundary_tag_first_fit_allocator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random ready, with one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Outputs are stable at the falling edge, just ahead of the edge that takes them.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_request(logic func, logic [15:0] bytes, logic [15:0] addr);
    bit taken;
    alloc_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {addr, bytes};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    r = sb.note_request(func, bytes, addr);
    if (func == FnAlloc && !r.failed) live_blocks.push_back(r.address);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic alloc_req(int unsigned bytes);
    send_request(FnAlloc, 16'(bytes), 16'($urandom));
  endtask

  // Frees a live block, with a random offset inside its first payload granule.
  task automatic free_live(int idx);
    int unsigned a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(FnFree, 16'($urandom), 16'(a + $urandom_range(GranuleBytes - 1)));
  endtask

  task automatic free_bad();
    int unsigned a;
    a = $urandom_range(16'hFFFF);
    if (a >= GranuleBytes && a / GranuleBytes - 1 < sb.top) a = a % GranuleBytes;
    send_request(FnFree, 16'($urandom), 16'(a));
  endtask

  task automatic random_request();
    int k;
    k = $urandom_range(99);
    if (k < 42 && live_blocks.size() > 0) free_live($urandom_range(live_blocks.size() - 1));
    else if (k < 47) free_bad();
    else if (k < 80) alloc_req($urandom_range(255));
    else if (k < 94) alloc_req($urandom_range(256, 4096));
    else alloc_req($urandom_range(8000, 65535));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    alloc_req(0);
    alloc_req(1);
    alloc_req(16);
    alloc_req(17);
    alloc_req(65535);
    alloc_req(64);
    send_request(FnFree, 16'h0000, 16'd0);
    send_request(FnFree, 16'hFFFF, 16'd15);
    send_request(FnFree, 16'h0000, 16'hFFFF);
    free_live(1);
    // The block with a free left neighbor merges with it.
    free_live(1);
    free_live(0);
    alloc_req(0);
    alloc_req(40);
    // A block with used neighbors is freed alone; a larger request goes to the heap top.
    free_live(live_blocks.size() - 1);
    alloc_req(1000);
    alloc_req(40000);
    alloc_req(30000);
    free_live(live_blocks.size() - 1);
    alloc_req(200);
    drain();

    repeat (180) random_request();
    drain();
    snd_idle_pct = 57;
    rcv_idle_pct = 24;
    repeat (180) random_request();
    drain();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (180) random_request();

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/btff_pkg.sv
rtl/core/btff_ctrl.sv
rtl/core/btff_dp.sv
rtl/core/boundary_tag_first_fit_allocator.sv
tb/sv/tb_boundary_tag_first_fit_allocator.sv
